// File: hdl/rci_pkg.sv
// shared types, constants and codes for the response curve interpolator
// no dependencies; imported by every module of the block
package rci_pkg;

  localparam int VW       = 16;  // value width
  localparam int MAXP     = 16;  // curve table depth
  localparam int PIW      = 4;   // point index width
  localparam int QDEPTH   = 4;   // front to back queue depth
  localparam int QAW      = 2;   // queue address width
  localparam int NST      = 42;  // back pipeline stages

  // register indexes
  localparam logic [1:0] CFG_AXIS_MIN    = 2'd0;
  localparam logic [1:0] CFG_AXIS_MAX    = 2'd1;
  localparam logic [1:0] CFG_POINT_COUNT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CLAMP = 2'd1;
  localparam logic [1:0] ST_SPAN  = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_PASS,
    KIND_POINT0,
    KIND_INTERP
  } kind_t;

  // classified beat handed from front to back
  typedef struct packed {
    kind_t           kind;
    logic [1:0]      status;
    logic [VW-1:0]   val;
    logic [PIW-1:0]  pidx;
    logic [VW-1:0]   vn;
    logic [VW-1:0]   span;
    logic [PIW-1:0]  bc;
  } item_t;

  // one back pipeline stage
  typedef struct packed {
    logic                vld;
    item_t               it;
    logic [VW-1:0]       bs;
    logic [4:0]          idx;
    logic [31:0]         rem;
    logic [VW-1:0]       t;
    logic [VW-1:0]       fs;
    logic signed [32:0]  p0;
    logic signed [32:0]  p1;
    logic                neg;
    logic [VW-1:0]       quo;
  } stage_t;

endpackage

// File: hdl/rci_front.sv
// front end: classifies each input beat and clamps the reading
// depends on rci_pkg
module rci_front import rci_pkg::*; (
  input  logic              mode,
  input  logic [VW-1:0]     axis_value,
  input  logic [PIW-1:0]    point_index,
  input  logic [VW-1:0]     point_value,
  input  logic [VW-1:0]     axis_min,
  input  logic [VW-1:0]     axis_max,
  input  logic [4:0]        point_count,
  output item_t             item
);

  logic [4:0]         n5;
  logic [4:0]         bc5;
  logic signed [16:0] span;
  logic signed [16:0] v;
  logic signed [16:0] amin;
  logic signed [16:0] amax;
  logic signed [16:0] vc;
  logic [16:0]        vn;

  // effective point count and span
  assign n5   = (point_count > 5'(MAXP)) ? 5'(MAXP) : point_count;
  assign bc5  = n5 - 5'd1;
  assign amin = $signed({axis_min[VW-1], axis_min});
  assign amax = $signed({axis_max[VW-1], axis_max});
  assign v    = $signed({axis_value[VW-1], axis_value});
  assign span = amax - amin;

  // clamp into range
  assign vc = (v < amin) ? amin : ((v > amax) ? amax : v);
  assign vn = 17'(vc - amin);

  // classify
  always_comb begin
    item        = '0;
    item.kind   = KIND_INTERP;
    item.status = ST_OK;
    item.val    = axis_value;
    item.pidx   = point_index;
    item.vn     = vn[VW-1:0];
    item.span   = span[VW-1:0];
    item.bc     = bc5[PIW-1:0];
    if (mode) begin
      item.kind = KIND_LOAD;
      item.val  = point_value;
    end else if (n5 == 5'd0) begin
      item.kind = KIND_PASS;
    end else if (n5 == 5'd1) begin
      item.kind = KIND_POINT0;
    end else if (span < $signed({12'd0, bc5})) begin
      item.kind   = KIND_POINT0;
      item.status = ST_SPAN;
    end else if (v < amin || v > amax) begin
      item.status = ST_CLAMP;
    end
  end

endmodule

// File: hdl/rci_fifo.sv
// short queue that decouples the front end from the back pipeline
// depends on rci_pkg
module rci_fifo import rci_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  item_t  wdata,
  output logic   full,
  input  logic   pop,
  output logic   nempty,
  output item_t  rdata
);

  item_t          buf_q [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   cnt;

  assign full   = (cnt == (QAW+1)'(QDEPTH));
  assign nempty = (cnt != '0);
  assign rdata  = buf_q[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (push) buf_q[wptr] <= wdata;
  end

endmodule

// File: hdl/rci_back.sv
// back pipeline: bucket size and index dividers, table access,
// interpolation products and final divider; holds the curve table
// depends on rci_pkg
module rci_back import rci_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_vld,
  input  item_t           head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [VW-1:0]   mapped_value,
  output logic [1:0]      status
);

  stage_t          st [1:NST];
  stage_t          nx [1:NST];
  stage_t          s0_in;
  logic            adv;
  logic [VW-1:0]   curve [MAXP];
  logic [VW-1:0]   rd0;
  logic [VW-1:0]   rd1;

  assign adv = !st[NST].vld || !out_stall;
  assign pop = adv && head_vld;

  // entry into the pipeline
  always_comb begin
    s0_in     = '0;
    s0_in.vld = head_vld;
    s0_in.it  = head;
  end

  for (genvar k = 1; k <= NST; k++) begin : g_st
    // quotient bit positions handled by this stage
    localparam int BB = (k <= 16) ? 16 - k : 0;
    localparam int IB = (k >= 17 && k <= 21) ? 21 - k : 0;
    localparam int QB = (k >= 26 && k <= 41) ? 41 - k : 0;

    stage_t          p;
    logic [4:0]      ra;
    logic [20:0]     curb;
    logic [20:0]     dvb;
    logic [31:0]     dvc;
    logic [4:0]      bm1;
    logic [4:0]      idxc;
    logic [20:0]     ib;
    logic [20:0]     fb;
    logic signed [16:0] a0;
    logic signed [16:0] a1;
    logic signed [33:0] sm;
    logic [33:0]     mag;

    if (k == 1) begin : g_first
      assign p = s0_in;
    end else begin : g_rest
      assign p = st[k-1];
    end

    always_comb begin
      nx[k] = p;
      ra    = '0;
      curb  = '0;
      dvb   = '0;
      dvc   = '0;
      bm1   = '0;
      idxc  = '0;
      ib    = '0;
      fb    = '0;
      a0    = '0;
      a1    = '0;
      sm    = '0;
      mag   = '0;
      if (k <= 16) begin
        // bucket size: span / bucket count, one bit a stage
        ra = {p.rem[3:0], p.it.span[BB]};
        if (ra >= {1'b0, p.it.bc}) begin
          nx[k].rem    = 32'(ra - {1'b0, p.it.bc});
          nx[k].bs[BB] = 1'b1;
        end else begin
          nx[k].rem = 32'(ra);
        end
      end else if (k <= 21) begin
        // bucket index: offset / bucket size
        curb = (k == 17) ? {5'd0, p.it.vn} : p.rem[20:0];
        dvb  = {5'd0, p.bs} << IB;
        if (curb >= dvb) begin
          nx[k].rem     = 32'(curb - dvb);
          nx[k].idx[IB] = 1'b1;
        end else begin
          nx[k].rem = 32'(curb);
        end
      end else if (k == 22) begin
        // clamp index, offset into bucket and stretched last bucket
        bm1  = {1'b0, p.it.bc} - 5'd1;
        idxc = (p.idx > bm1) ? bm1 : p.idx;
        ib   = idxc * p.bs;
        fb   = bm1 * p.bs;
        nx[k].idx = (p.it.kind == KIND_INTERP) ? idxc : 5'd0;
        nx[k].t   = p.it.vn - ib[VW-1:0];
        nx[k].fs  = (idxc == bm1) ? p.it.span - fb[VW-1:0] : p.bs;
      end else if (k == 23) begin
        // table read issued at this edge
        nx[k] = p;
      end else if (k == 24) begin
        // weighted products
        a0 = $signed({1'b0, p.fs - p.t});
        a1 = $signed({1'b0, p.t});
        nx[k].p0 = a0 * $signed(rd0);
        nx[k].p1 = a1 * $signed(rd1);
        if (p.it.kind == KIND_POINT0) nx[k].it.val = rd0;
      end else if (k == 25) begin
        // sum and magnitude
        sm  = {p.p0[32], p.p0} + {p.p1[32], p.p1};
        mag = sm[33] ? 34'(-sm) : 34'(sm);
        nx[k].neg = sm[33];
        nx[k].rem = mag[31:0];
      end else if (k <= 41) begin
        // interpolation divide, truncated toward zero
        dvc = {16'd0, p.fs} << QB;
        if (p.rem >= dvc) begin
          nx[k].rem     = p.rem - dvc;
          nx[k].quo[QB] = 1'b1;
        end
      end else begin
        // result select
        case (p.it.kind)
          KIND_LOAD:   nx[k].it.val = '0;
          KIND_INTERP: nx[k].it.val = p.neg ? VW'(-p.quo) : p.quo;
          default:     nx[k].it.val = p.it.val;
        endcase
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NST; i++) st[i].vld <= 1'b0;
    end else if (adv) begin
      for (int i = 1; i <= NST; i++) st[i] <= nx[i];
    end
  end

  // curve table: loads write and maps read at the same stage, in order
  always_ff @(posedge clk) begin
    if (adv) begin
      if (st[22].vld && st[22].it.kind == KIND_LOAD) begin
        curve[st[22].it.pidx] <= st[22].it.val;
      end
      rd0 <= curve[st[22].idx[PIW-1:0]];
      rd1 <= curve[st[22].idx[PIW-1:0] + 1'b1];
    end
  end

  assign out_valid    = st[NST].vld;
  assign mapped_value = st[NST].it.val;
  assign status       = st[NST].it.status;

`ifndef ASSERT_OFF
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && st[NST].it.kind == KIND_LOAD) |-> (mapped_value == '0 && status == ST_OK))
    else $error("load beat with nonzero result");
  a_interp_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && st[NST].it.kind == KIND_INTERP) |-> (status != ST_SPAN))
    else $error("interpolated beat with span error");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (st[22].vld && st[22].it.kind == KIND_INTERP) |-> ({1'b0, st[22].idx} < {2'b0, st[22].it.bc}))
    else $error("bucket index past last bucket");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (st[41].vld && st[41].it.kind == KIND_INTERP) |-> (st[41].rem < {16'd0, st[41].fs}))
    else $error("interpolation remainder not below bucket size");
`endif

endmodule

// File: hdl/axis_response_curve_interp.sv
// top level of the response curve interpolator: registers, front, queue, back
// depends on rci_pkg, rci_front, rci_fifo, rci_back
//
// usage:
//   input channel (in_valid / in_stall) carries one beat per item: mode 0 maps
//   axis_value through the curve, mode 1 writes point_value at point_index.
//   output channel (out_valid / out_stall) returns one beat per input beat,
//   in order: mapped_value and status (0 ok, 1 clamped, 2 span too small).
//   configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   axis_min, axis_max and point_count; cfg_ready is always high. write it
//   only while no beat is in flight.
// pipeline: the back pipeline holds bit-serial dividers (16 + 5 + 16 stages).
// throughput: one beat per cycle while the output is not stalled.
// reset: clears the pipeline, queue and registers; the curve table holds no
//   reset value, so every point must be loaded before a map reads it.
// stall: a stalled output freezes the back pipeline; the 4-entry queue then
//   fills and in_stall rises when it is full.
module axis_response_curve_interp import rci_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [VW-1:0]     axis_value,
  input  logic [PIW-1:0]    point_index,
  input  logic [VW-1:0]     point_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VW-1:0]     mapped_value,
  output logic [1:0]        status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [VW-1:0]     cfg_data
);

  logic [VW-1:0] axis_min;
  logic [VW-1:0] axis_max;
  logic [4:0]    point_count;
  item_t         fitem;
  item_t         head;
  logic          full;
  logic          head_vld;
  logic          pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_min    <= {1'b1, {(VW-1){1'b0}}};
      axis_max    <= {1'b0, {(VW-1){1'b1}}};
      point_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_AXIS_MIN:    axis_min    <= cfg_data;
        CFG_AXIS_MAX:    axis_max    <= cfg_data;
        CFG_POINT_COUNT: point_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  rci_front u_front (
    .mode        (mode),
    .axis_value  (axis_value),
    .point_index (point_index),
    .point_value (point_value),
    .axis_min    (axis_min),
    .axis_max    (axis_max),
    .point_count (point_count),
    .item        (fitem)
  );

  rci_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (in_valid && !in_stall),
    .wdata  (fitem),
    .full   (full),
    .pop    (pop),
    .nempty (head_vld),
    .rdata  (head)
  );

  rci_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_vld     (head_vld),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mapped_value (mapped_value),
    .status       (status)
  );

endmodule
